// ===== sv/bcd_pkg.sv =====
// Package for the buffer cache directory: function codes, result codes, types.
// No dependencies.
`timescale 1ns / 1ps
package bcd_pkg;
   localparam logic [2:0] FUNC_GET   = 3'd0;
   localparam logic [2:0] FUNC_PUT   = 3'd1;
   localparam logic [2:0] FUNC_DIRTY = 3'd2;
   localparam logic [2:0] FUNC_SYNC  = 3'd3;
   localparam logic [2:0] FUNC_SALL  = 3'd4;
   localparam logic [2:0] FUNC_INVAL = 3'd5;

   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_WBACK = 2'd1;
   localparam logic [1:0] KIND_FILL  = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_INVAL  = 2'd1;
   localparam logic [1:0] ST_PINNED = 2'd2;

   localparam int          PIN_BITS   = 16;
   localparam int          STAMP_BITS = 64;
   localparam logic [15:0] PIN_MAX    = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  dev_id;
      logic [31:0] blk_num;
      logic [3:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [3:0]  out_slot;
      logic [7:0]  out_dev;
      logic [31:0] out_block;
      logic        last;
   } rsp_type;
endpackage

// ===== sv/bcd_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on bcd_pkg for payload types.
`timescale 1ns / 1ps
interface bcd_req_if import bcd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bcd_rsp_if import bcd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/buffer_cache_directory_lru.sv =====
// Channel   | Dir | Handshake    | Payload
// req       | in  | valid/ready  | func, dev_id, blk_num, slot_index
// rsp       | out | valid/ready  | kind, status, out_slot, out_dev, out_block, last
// One sequencer walks the slots one per cycle (a sync all / invalidate walk only while the
// output is free); get uses one shared compare unit (tag match, free slot, oldest stamp),
// then loads its hit reply or first request: a fill request before the reply, or for a dirty
// victim a write-back, a fill request and the reply. Sync all and invalidate load write-backs
// in the walk, then the final reply. Put, mark dirty and sync load the reply from decode
// (sync: a write-back first). Each result waits in the output register until taken; the
// sequencer stalls meanwhile, and a new request is taken only when idle with nothing waiting.
// Synchronous active-high reset clears all directory flags, pins, stamps and clock.
// Depends on bcd_pkg and bcd_if.
`timescale 1ns / 1ps
module buffer_cache_directory_lru import bcd_pkg::*; #(
   parameter int SLOTS      = 16,
   parameter int DEV_BITS   = 8,
   parameter int BLOCK_BITS = 32
) (
   input logic     clock,
   input logic     reset,
   bcd_req_if.sink req,
   bcd_rsp_if.source rsp
);
   localparam int SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CB = $clog2(SLOTS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HIT  = 3'd1;
   localparam logic [2:0] S_VIC  = 3'd2;
   localparam logic [2:0] S_DEC  = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_FILL = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_WFIL = 3'd7;

   // directory storage
   logic [SLOTS-1:0]      used_ff, dirty_ff;
   logic [DEV_BITS-1:0]   dev_ff   [SLOTS];
   logic [BLOCK_BITS-1:0] blk_ff   [SLOTS];
   logic [PIN_BITS-1:0]   pins_ff  [SLOTS];
   logic [STAMP_BITS-1:0] stamp_ff [SLOTS];
   logic [STAMP_BITS-1:0] clock_ff;

   // sequencer state
   logic [2:0]            state_ff;
   logic [2:0]            state_in;
   logic [CB-1:0]         cnt_ff;
   req_type               r_ff;
   logic [DEV_BITS-1:0]   devq_ff;
   logic [BLOCK_BITS-1:0] blkq_ff;
   logic                  hit_ff, free_ff, clean_ff, any_ff;
   logic [SB-1:0]         hslot_ff, fslot_ff, cslot_ff, aslot_ff;
   logic [STAMP_BITS-1:0] cst_ff, ast_ff;
   logic                  ov_ff;
   rsp_type               od_ff;

   logic [SB-1:0] cur;
   logic [SB-1:0] ridx;
   logic          ridx_ok;
   assign cur     = cnt_ff[SB-1:0];
   assign ridx    = SB'(r_ff.slot_index);
   assign ridx_ok = ({28'd0, r_ff.slot_index} < 32'(SLOTS));

   assign req.ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.data  = od_ff;

   function automatic rsp_type mk(logic [1:0] k, logic [1:0] st, logic [3:0] sl,
                                  logic [7:0] d, logic [31:0] b, logic l);
      rsp_type t;
      t.kind = k; t.status = st; t.out_slot = sl; t.out_dev = d;
      t.out_block = b; t.last = l;
      return t;
   endfunction

   logic [7:0]  odev;
   logic [31:0] oblk;
   logic [7:0]  qdev;
   logic [31:0] qblk;
   assign odev = 8'(dev_ff[cur]);
   assign oblk = 32'(blk_ff[cur]);
   assign qdev = 8'(devq_ff);
   assign qblk = 32'(blkq_ff);

   // shared compare unit: one slot per cycle
   logic c_match, c_older_clean, c_older_any;
   assign c_match = used_ff[cur] && dev_ff[cur] == devq_ff && blk_ff[cur] == blkq_ff;
   assign c_older_clean = pins_ff[cur] == '0 && !dirty_ff[cur] &&
                          (!clean_ff || stamp_ff[cur] < cst_ff);
   assign c_older_any = pins_ff[cur] == '0 && (!any_ff || stamp_ff[cur] < ast_ff);

   // walk of sync all / invalidate: unpinned slot of the device (invalidate); write-back needed
   logic scan_match, scan_wb;
   assign scan_match = used_ff[cur] && dev_ff[cur] == devq_ff && pins_ff[cur] == '0;
   assign scan_wb    = (r_ff.func == FUNC_SALL) ? (used_ff[cur] && dirty_ff[cur]) :
                                                  (scan_match && dirty_ff[cur]);

   logic out_free;
   assign out_free = !ov_ff || rsp.ready;
   logic scan_end;
   assign scan_end = (cnt_ff == CB'(SLOTS - 1));

   // next state and output register load
   logic out_load;
   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) state_in = S_DEC;
         S_DEC: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               unique case (r_ff.func)
                  FUNC_GET: begin
                     if (devq_ff != '0) begin out_load = 1'b0; state_in = S_HIT; end
                  end
                  FUNC_SYNC: begin
                     if (ridx_ok && used_ff[ridx] && dirty_ff[ridx]) state_in = S_DEC;
                  end
                  FUNC_SALL: begin out_load = 1'b0; state_in = S_SCAN; end
                  FUNC_INVAL: begin
                     if (devq_ff != '0) begin out_load = 1'b0; state_in = S_SCAN; end
                  end
                  default: ;
               endcase
            end
         end
         S_HIT: if (scan_end) state_in = S_VIC;
         S_VIC: begin
            if (out_free) begin
               out_load = 1'b1;
               if (hit_ff) state_in = S_IDLE;
               else if (free_ff || clean_ff) state_in = S_FILL;
               else if (any_ff) state_in = S_WFIL;
               else state_in = S_IDLE;
            end
         end
         S_WFIL: if (out_free) begin out_load = 1'b1; state_in = S_FILL; end
         S_FILL: if (out_free) begin out_load = 1'b1; state_in = S_IDLE; end
         S_SCAN: begin
            if (out_free) begin
               out_load = scan_wb;
               if (scan_end) state_in = S_FIN;
            end
         end
         S_FIN: if (out_free) begin out_load = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (out_load) ov_ff <= 1'b1;
      else if (rsp.ready) ov_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         dirty_ff <= '0;
         clock_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            dev_ff[i]   <= '0;
            blk_ff[i]   <= '0;
            pins_ff[i]  <= '0;
            stamp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  r_ff     <= req.data;
                  devq_ff  <= DEV_BITS'(req.data.dev_id);
                  blkq_ff  <= BLOCK_BITS'(req.data.blk_num);
                  cnt_ff   <= '0;
                  hit_ff   <= 1'b0; free_ff <= 1'b0;
                  clean_ff <= 1'b0; any_ff  <= 1'b0;
               end
            end
            S_DEC: begin
               if (out_free) begin
                  unique case (r_ff.func) inside
                     FUNC_GET: begin
                        if (devq_ff == '0)
                           od_ff <= mk(KIND_REPLY, ST_INVAL, 4'd0, 8'd0, 32'd0, 1'b1);
                     end
                     FUNC_PUT, FUNC_DIRTY: begin
                        if (!ridx_ok)
                           od_ff <= mk(KIND_REPLY, ST_INVAL, r_ff.slot_index, 8'd0, 32'd0, 1'b1);
                        else begin
                           od_ff <= mk(KIND_REPLY, ST_OK, r_ff.slot_index, 8'd0, 32'd0, 1'b1);
                           if (r_ff.func == FUNC_PUT) begin
                              if (pins_ff[ridx] != '0) pins_ff[ridx] <= pins_ff[ridx] - 1'b1;
                           end else if (used_ff[ridx]) dirty_ff[ridx] <= 1'b1;
                        end
                     end
                     FUNC_SYNC: begin
                        if (!ridx_ok || !used_ff[ridx])
                           od_ff <= mk(KIND_REPLY, ST_INVAL, r_ff.slot_index, 8'd0, 32'd0, 1'b1);
                        else if (dirty_ff[ridx]) begin
                           // write-back first, reply on the next pass
                           od_ff <= mk(KIND_WBACK, ST_OK, r_ff.slot_index, 8'(dev_ff[ridx]),
                                       32'(blk_ff[ridx]), 1'b0);
                           dirty_ff[ridx] <= 1'b0;
                        end else
                           od_ff <= mk(KIND_REPLY, ST_OK, r_ff.slot_index, 8'd0, 32'd0, 1'b1);
                     end
                     FUNC_SALL: ;
                     FUNC_INVAL: begin
                        if (devq_ff == '0)
                           od_ff <= mk(KIND_REPLY, ST_INVAL, 4'd0, 8'd0, 32'd0, 1'b1);
                     end
                     default: od_ff <= mk(KIND_REPLY, ST_INVAL, 4'd0, 8'd0, 32'd0, 1'b1);
                  endcase
               end
            end
            S_HIT: begin
               // gather hit, first free, oldest clean and oldest unpinned in one walk
               if (c_match && !hit_ff) begin hit_ff <= 1'b1; hslot_ff <= cur; end
               if (!used_ff[cur] && !free_ff) begin free_ff <= 1'b1; fslot_ff <= cur; end
               if (c_older_clean) begin
                  clean_ff <= 1'b1; cslot_ff <= cur; cst_ff <= stamp_ff[cur];
               end
               if (c_older_any) begin
                  any_ff <= 1'b1; aslot_ff <= cur; ast_ff <= stamp_ff[cur];
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            S_VIC: begin
               if (out_free) begin
                  if (hit_ff) begin
                     if (pins_ff[hslot_ff] != PIN_MAX)
                        pins_ff[hslot_ff] <= pins_ff[hslot_ff] + 1'b1;
                     stamp_ff[hslot_ff] <= clock_ff + 1'b1;
                     clock_ff <= clock_ff + 1'b1;
                     od_ff <= mk(KIND_REPLY, ST_OK, 4'(hslot_ff), qdev, qblk, 1'b1);
                  end else if (free_ff) begin
                     cnt_ff <= CB'(fslot_ff);
                     od_ff <= mk(KIND_FILL, ST_OK, 4'(fslot_ff), qdev, qblk, 1'b0);
                  end else if (clean_ff) begin
                     cnt_ff <= CB'(cslot_ff);
                     od_ff <= mk(KIND_FILL, ST_OK, 4'(cslot_ff), qdev, qblk, 1'b0);
                  end else if (any_ff) begin
                     // dirty victim: write-back goes out ahead of the fill
                     cnt_ff <= CB'(aslot_ff);
                     od_ff <= mk(KIND_WBACK, ST_OK, 4'(aslot_ff), 8'(dev_ff[aslot_ff]),
                                 32'(blk_ff[aslot_ff]), 1'b0);
                  end else
                     od_ff <= mk(KIND_REPLY, ST_PINNED, 4'd0, 8'd0, 32'd0, 1'b1);
               end
            end
            S_WFIL: begin
               if (out_free) od_ff <= mk(KIND_FILL, ST_OK, 4'(cur), qdev, qblk, 1'b0);
            end
            S_FILL: begin
               // install the new tag in the victim slot
               if (out_free) begin
                  dev_ff[cur]   <= devq_ff;
                  blk_ff[cur]   <= blkq_ff;
                  dirty_ff[cur] <= 1'b0;
                  used_ff[cur]  <= 1'b1;
                  pins_ff[cur]  <= PIN_BITS'(1);
                  stamp_ff[cur] <= clock_ff + 1'b1;
                  clock_ff      <= clock_ff + 1'b1;
                  od_ff <= mk(KIND_REPLY, ST_OK, 4'(cur), qdev, qblk, 1'b1);
               end
            end
            S_SCAN: begin
               if (out_free) begin
                  if (r_ff.func == FUNC_SALL) begin
                     if (used_ff[cur] && dirty_ff[cur]) begin
                        dirty_ff[cur] <= 1'b0;
                        od_ff <= mk(KIND_WBACK, ST_OK, 4'(cur), odev, oblk, 1'b0);
                     end
                  end else if (scan_match) begin
                     if (dirty_ff[cur])
                        od_ff <= mk(KIND_WBACK, ST_OK, 4'(cur), odev, oblk, 1'b0);
                     dev_ff[cur] <= '0; blk_ff[cur] <= '0; dirty_ff[cur] <= 1'b0;
                     used_ff[cur] <= 1'b0; stamp_ff[cur] <= '0;
                  end
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_FIN: begin
               if (out_free) od_ff <= mk(KIND_REPLY, ST_OK, 4'd0, 8'd0, 32'd0, 1'b1);
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== sv/bcd_checker.sv =====
// Port-level checker for buffer_cache_directory_lru, with its bind.
// Depends on bcd_pkg and bcd_if.
`timescale 1ns / 1ps
module bcd_checker import bcd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // a stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   // requests carry success status and are not last
   a_req_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_REPLY |-> rsp_data.status == ST_OK && !rsp_data.last)
      else $error("request with status or last");
   // every reply is last
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_REPLY |-> rsp_data.last)
      else $error("reply not last");
   // no new request taken while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("accepting while result pending");
endmodule

bind buffer_cache_directory_lru bcd_checker u_bcd_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
